### design/flra_pkg.sv
`default_nettype none

package flra_pkg;

  // Field widths
  localparam int unsigned FREQ_W     = 22;
  localparam int unsigned ID_W       = 16;
  localparam int unsigned ACTION_W   = 2;
  localparam int unsigned CFG_IDX_W  = 2;

  // Default table depth
  localparam int unsigned TABLE_DEPTH_DEF = 16;

  // Register reset values
  localparam logic [FREQ_W-1:0] HW_MAX_RESET = FREQ_W'(1200000);
  localparam logic [FREQ_W-1:0] HW_MIN_RESET = FREQ_W'(100000);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HW_MAX = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_HW_MIN = CFG_IDX_W'(1);

  // Action codes: bit 0 selects the floor table, bit 1 marks a release
  localparam logic [ACTION_W-1:0] ACT_SET_CEIL = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_SET_FLOOR = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_REL_CEIL = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_REL_FLOOR = 2'd3;
  localparam int unsigned ACT_FLOOR_BIT   = 0;
  localparam int unsigned ACT_RELEASE_BIT = 1;

  // Result kind codes
  localparam logic KIND_CEIL  = 1'b0;
  localparam logic KIND_FLOOR = 1'b1;

  // Status codes
  localparam logic STAT_OK   = 1'b0;
  localparam logic STAT_FULL = 1'b1;

  // One stored limit entry
  typedef struct packed {
    logic [ID_W-1:0]   owner;
    logic [FREQ_W-1:0] freq;
  } entry_t;

  // Hardware bounds from the register file
  typedef struct packed {
    logic [FREQ_W-1:0] hw_max;
    logic [FREQ_W-1:0] hw_min;
  } bounds_t;

  // One result transfer
  typedef struct packed {
    logic              kind;
    logic [FREQ_W-1:0] khz;
    logic              status;
  } result_t;

endpackage

`default_nettype wire

### design/freq_limit_request_aggregator_top.sv
`default_nettype none

// Frequency limit request aggregator. A request is taken when start is high
// and busy is low; it sets or releases one requester's ceiling or floor and
// returns the effective limit of that table after the change on out_* for a
// single cycle, flagged by out_valid, after the scan and the store. The
// result cannot be stalled: the receiver must capture it in that cycle. busy
// stays high through the scan and the final store, so a new request is not
// taken before the last one has been stored; the scan reads the entry
// memory one entry per cycle through its single read port. Register writes
// (cfg_ready is always high) must only be issued while busy is low and no
// result is pending.
module freq_limit_request_aggregator_top #(
  parameter int unsigned TABLE_DEPTH = flra_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [flra_pkg::ACTION_W-1:0]  in_action,
  input  wire logic [flra_pkg::ID_W-1:0]      in_requester_id,
  input  wire logic [flra_pkg::FREQ_W-1:0]    in_freq_khz,
  output logic                                out_valid,
  output logic                                out_limit_kind,
  output logic [flra_pkg::FREQ_W-1:0]         out_limit_khz,
  output logic                                out_status,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [flra_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [flra_pkg::FREQ_W-1:0]    cfg_data
);

  flra_pkg::bounds_t bounds_r, bounds_nxt;
  flra_pkg::result_t res;

  // Register file
  always_comb begin
    bounds_nxt = bounds_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        flra_pkg::REG_HW_MAX: bounds_nxt.hw_max = cfg_data;
        flra_pkg::REG_HW_MIN: bounds_nxt.hw_min = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bounds_r.hw_max <= flra_pkg::HW_MAX_RESET;
      bounds_r.hw_min <= flra_pkg::HW_MIN_RESET;
    end else begin
      bounds_r <= bounds_nxt;
    end
  end

  assign cfg_ready = 1'b1;

  flra_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .action       (in_action),
    .requester_id (in_requester_id),
    .freq_khz     (in_freq_khz),
    .bounds       (bounds_r),
    .res_valid    (out_valid),
    .res          (res)
  );

  assign out_limit_kind = res.kind;
  assign out_limit_khz  = res.khz;
  assign out_status     = res.status;

endmodule

`default_nettype wire

### design/flra_entry_ram.sv
`default_nettype none

// Entry store for both tables: one write port, one registered read port.
module flra_entry_ram #(
  parameter int unsigned ADDR_W = 5
) (
  input  wire logic                  clk,
  input  wire logic                  rd_en,
  input  wire logic [ADDR_W-1:0]     rd_addr,
  output flra_pkg::entry_t           rd_data,
  input  wire logic                  wr_en,
  input  wire logic [ADDR_W-1:0]     wr_addr,
  input  wire flra_pkg::entry_t      wr_data
);

  localparam int unsigned WORDS = 1 << ADDR_W;

  flra_pkg::entry_t mem [0:WORDS-1];
  flra_pkg::entry_t rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

### design/flra_ctrl.sv
`default_nettype none

// Request sequencer: scans one table entry per cycle, drops the requester's
// old entry, finds the lowest free slot and folds the aggregate, then stores
// the new entry when a set finds a free slot and reports the effective limit.
module flra_ctrl #(
  parameter int unsigned TABLE_DEPTH = flra_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [flra_pkg::ACTION_W-1:0] action,
  input  wire logic [flra_pkg::ID_W-1:0]     requester_id,
  input  wire logic [flra_pkg::FREQ_W-1:0]   freq_khz,
  input  wire flra_pkg::bounds_t             bounds,
  output logic                               res_valid,
  output flra_pkg::result_t                  res
);

  localparam int unsigned IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned ADDR_W = IDX_W + 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);
  localparam logic [IDX_W:0]   DEPTH_CNT = (IDX_W+1)'(TABLE_DEPTH);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0]                    state_r, state_nxt;
  logic                          kind_r, kind_nxt;
  logic                          set_r, set_nxt;
  logic [flra_pkg::ID_W-1:0]     id_r, id_nxt;
  logic [flra_pkg::FREQ_W-1:0]   freq_r, freq_nxt;
  logic [IDX_W:0]                rd_cnt_r, rd_cnt_nxt;
  logic                          chk_v_r, chk_v_nxt;
  logic [IDX_W-1:0]              chk_idx_r, chk_idx_nxt;
  logic                          any_r, any_nxt;
  logic [flra_pkg::FREQ_W-1:0]   best_r, best_nxt;
  logic                          free_found_r, free_found_nxt;
  logic [IDX_W-1:0]              free_idx_r, free_idx_nxt;
  logic [TABLE_DEPTH-1:0]        ceil_vld_r, ceil_vld_nxt;
  logic [TABLE_DEPTH-1:0]        floor_vld_r, floor_vld_nxt;
  logic                          res_valid_r, res_valid_nxt;
  flra_pkg::result_t             res_r, res_nxt;

  logic                          rd_en;
  logic [ADDR_W-1:0]             rd_addr;
  flra_pkg::entry_t              rd_data;
  logic                          wr_en;
  logic [ADDR_W-1:0]             wr_addr;
  flra_pkg::entry_t              wr_data;

  logic                          cur_vld;
  logic                          match;
  logic                          better;
  logic                          insert;
  logic                          new_better;
  logic [flra_pkg::FREQ_W-1:0]   empty_val;
  logic [flra_pkg::FREQ_W-1:0]   final_limit;

  flra_entry_ram #(
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  // Read issue during the scan
  assign rd_en   = (state_r == ST_SCAN) && (rd_cnt_r < DEPTH_CNT);
  assign rd_addr = {kind_r, rd_cnt_r[IDX_W-1:0]};

  // Entry check on returned read data
  assign cur_vld = kind_r ? floor_vld_r[chk_idx_r] : ceil_vld_r[chk_idx_r];
  assign match   = cur_vld && (rd_data.owner == id_r);
  assign better  = kind_r ? (rd_data.freq > best_r) : (rd_data.freq < best_r);

  // Final aggregate including the new entry
  assign insert      = set_r && free_found_r;
  assign new_better  = kind_r ? (freq_r > best_r) : (freq_r < best_r);
  assign empty_val   = kind_r ? bounds.hw_min : bounds.hw_max;
  assign final_limit = (insert && (!any_r || new_better)) ? freq_r :
                       any_r ? best_r : empty_val;

  // Store of the new entry
  assign wr_en         = (state_r == ST_FIN) && insert;
  assign wr_addr       = {kind_r, free_idx_r};
  assign wr_data.owner = id_r;
  assign wr_data.freq  = freq_r;

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    kind_nxt       = kind_r;
    set_nxt        = set_r;
    id_nxt         = id_r;
    freq_nxt       = freq_r;
    rd_cnt_nxt     = rd_cnt_r;
    chk_v_nxt      = 1'b0;
    chk_idx_nxt    = chk_idx_r;
    any_nxt        = any_r;
    best_nxt       = best_r;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    ceil_vld_nxt   = ceil_vld_r;
    floor_vld_nxt  = floor_vld_r;
    res_valid_nxt  = 1'b0;
    res_nxt        = res_r;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          kind_nxt       = action[flra_pkg::ACT_FLOOR_BIT];
          set_nxt        = !action[flra_pkg::ACT_RELEASE_BIT];
          id_nxt         = requester_id;
          freq_nxt       = freq_khz;
          rd_cnt_nxt     = '0;
          any_nxt        = 1'b0;
          free_found_nxt = 1'b0;
          state_nxt      = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (rd_en) begin
          rd_cnt_nxt  = rd_cnt_r + 1'b1;
          chk_v_nxt   = 1'b1;
          chk_idx_nxt = rd_cnt_r[IDX_W-1:0];
        end
        if (chk_v_r) begin
          if (cur_vld && !match) begin
            // kept entry takes part in the aggregate
            if (!any_r || better) begin
              best_nxt = rd_data.freq;
            end
            any_nxt = 1'b1;
          end else if (!free_found_r) begin
            free_found_nxt = 1'b1;
            free_idx_nxt   = chk_idx_r;
          end
          // drop the requester's old entry
          if (match) begin
            if (kind_r) begin
              floor_vld_nxt[chk_idx_r] = 1'b0;
            end else begin
              ceil_vld_nxt[chk_idx_r] = 1'b0;
            end
          end
          if (chk_idx_r == LAST_IDX) begin
            state_nxt = ST_FIN;
          end
        end
      end
      ST_FIN: begin
        if (insert) begin
          if (kind_r) begin
            floor_vld_nxt[free_idx_r] = 1'b1;
          end else begin
            ceil_vld_nxt[free_idx_r] = 1'b1;
          end
        end
        res_valid_nxt = 1'b1;
        res_nxt.kind   = kind_r ? flra_pkg::KIND_FLOOR : flra_pkg::KIND_CEIL;
        res_nxt.khz    = final_limit;
        res_nxt.status = (set_r && !free_found_r) ? flra_pkg::STAT_FULL
                                                  : flra_pkg::STAT_OK;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      chk_v_r     <= 1'b0;
      ceil_vld_r  <= '0;
      floor_vld_r <= '0;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      chk_v_r     <= chk_v_nxt;
      ceil_vld_r  <= ceil_vld_nxt;
      floor_vld_r <= floor_vld_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    kind_r       <= kind_nxt;
    set_r        <= set_nxt;
    id_r         <= id_nxt;
    freq_r       <= freq_nxt;
    rd_cnt_r     <= rd_cnt_nxt;
    chk_idx_r    <= chk_idx_nxt;
    any_r        <= any_nxt;
    best_r       <= best_nxt;
    free_found_r <= free_found_nxt;
    free_idx_r   <= free_idx_nxt;
    res_r        <= res_nxt;
  end

  assign busy      = (state_r != ST_IDLE);
  assign res_valid = res_valid_r;
  assign res       = res_r;

endmodule

`default_nettype wire
